FILE: rtl/ldbb_pkg.sv
package ldbb_pkg;

    // Field widths of one jet.
    localparam int PT_W  = 16;
    localparam int ETA_W = 12;
    localparam int PHI_W = 12;
    localparam int IDX_W = 6;

    // Configuration register widths and reset values.
    localparam int ETA_CUT_W  = 11;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [PT_W-1:0]      PT_CUT_RESET  = 16'd80;
    localparam logic [ETA_CUT_W-1:0] ETA_CUT_RESET = 11'd640;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_PT_CUT  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ETA_CUT = 1'b1;

    // Stream widths.
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 16;

    // One radian is about 651.9 phi steps, so a folded difference within one
    // radian of pi lies in [1397, 2048]; on the raw difference that is
    // [1397, 2699].
    localparam logic [PHI_W-1:0] DPHI_LOW  = 12'd1397;
    localparam logic [PHI_W-1:0] DPHI_HIGH = 12'd2699;

    localparam int MAX_JETS_DEFAULT = 64;

    // Kinematics of one kept jet.
    typedef struct packed {
        logic                    tight;
        logic        [PHI_W-1:0] phi;
        logic signed [ETA_W-1:0] eta;
        logic        [PT_W-1:0]  pt;
    } jet_core_t;

    // Leading pair of a finished event, handed to the judging stage.
    typedef struct packed {
        jet_core_t        lead;
        jet_core_t        second;
        logic [IDX_W-1:0] lead_idx;
        logic [IDX_W-1:0] second_idx;
    } pair_t;

    // One result of an event.
    typedef struct packed {
        logic             dijet;
        logic [IDX_W-1:0] lead_idx;
        logic [IDX_W-1:0] second_idx;
    } result_t;

endpackage

FILE: rtl/ldbb_rank.sv
module ldbb_rank
    import ldbb_pkg::*;
#(
    parameter int MAX_JETS = MAX_JETS_DEFAULT
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      step,
    input  logic      jet_valid,
    input  jet_core_t jet,
    input  logic      last,
    output pair_t     pair
);

    localparam int CNT_W = $clog2(MAX_JETS + 1);
    localparam int POS_W = $clog2(MAX_JETS);

    jet_core_t        lead_reg, lead_next, lead_upd;
    jet_core_t        second_reg, second_next, second_upd;
    logic [POS_W-1:0] lead_pos_reg, lead_pos_next, lead_pos_upd;
    logic [POS_W-1:0] second_pos_reg, second_pos_next, second_pos_upd;
    logic [CNT_W-1:0] jet_count_reg, jet_count_next, jet_count_upd;
    logic [POS_W-1:0] pos;
    logic             take;

    // Insert the new jet into the running top two with strict compares.
    always_comb
    begin
        take           = jet_valid && (jet_count_reg < CNT_W'(MAX_JETS));
        pos            = jet_count_reg[POS_W-1:0];
        lead_upd       = lead_reg;
        second_upd     = second_reg;
        lead_pos_upd   = lead_pos_reg;
        second_pos_upd = second_pos_reg;
        jet_count_upd  = jet_count_reg;
        if (take)
        begin
            jet_count_upd = jet_count_reg + CNT_W'(1);
            if (jet.pt > lead_reg.pt)
            begin
                second_upd     = lead_reg;
                second_pos_upd = lead_pos_reg;
                lead_upd       = jet;
                lead_pos_upd   = pos;
            end
            else if (jet.pt > second_reg.pt)
            begin
                second_upd     = jet;
                second_pos_upd = pos;
            end
        end
    end

    // The pair as it stands after this item; only sampled on the last item.
    always_comb
    begin
        pair.lead       = lead_upd;
        pair.second     = second_upd;
        pair.lead_idx   = IDX_W'(lead_pos_upd);
        pair.second_idx = IDX_W'(second_pos_upd);
    end

    // The last item of an event clears the event state.
    always_comb
    begin
        lead_next       = lead_reg;
        second_next     = second_reg;
        lead_pos_next   = lead_pos_reg;
        second_pos_next = second_pos_reg;
        jet_count_next  = jet_count_reg;
        if (step)
        begin
            if (last)
            begin
                lead_next       = '0;
                second_next     = '0;
                lead_pos_next   = '0;
                second_pos_next = '0;
                jet_count_next  = '0;
            end
            else
            begin
                lead_next       = lead_upd;
                second_next     = second_upd;
                lead_pos_next   = lead_pos_upd;
                second_pos_next = second_pos_upd;
                jet_count_next  = jet_count_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lead_reg       <= '0;
            second_reg     <= '0;
            lead_pos_reg   <= '0;
            second_pos_reg <= '0;
            jet_count_reg  <= '0;
        end
        else
        begin
            lead_reg       <= lead_next;
            second_reg     <= second_next;
            lead_pos_reg   <= lead_pos_next;
            second_pos_reg <= second_pos_next;
            jet_count_reg  <= jet_count_next;
        end
    end

endmodule

FILE: rtl/ldbb_judge.sv
module ldbb_judge
    import ldbb_pkg::*;
(
    input  pair_t                pair,
    input  logic [PT_W-1:0]      pt_cut,
    input  logic [ETA_CUT_W-1:0] eta_cut,
    output result_t              result
);

    logic [ETA_W-1:0] lead_abs_eta;
    logic [ETA_W-1:0] second_abs_eta;
    logic             lead_pass;
    logic             second_pass;
    logic [PHI_W-1:0] dphi;
    logic             back_to_back;
    logic             dijet;

    // Magnitude of eta; -2048 maps to 2048, which still fits unsigned.
    assign lead_abs_eta   = pair.lead.eta[ETA_W-1] ? ETA_W'(-pair.lead.eta)
                                                   : ETA_W'(pair.lead.eta);
    assign second_abs_eta = pair.second.eta[ETA_W-1] ? ETA_W'(-pair.second.eta)
                                                     : ETA_W'(pair.second.eta);

    // Per-jet cuts. A nonzero pt is implied by pt above the cut.
    assign lead_pass   = (pair.lead.pt != '0) && (pair.lead.pt > pt_cut)
                         && (lead_abs_eta < ETA_W'(eta_cut)) && pair.lead.tight;
    assign second_pass = (pair.second.pt != '0) && (pair.second.pt > pt_cut)
                         && (second_abs_eta < ETA_W'(eta_cut)) && pair.second.tight;

    // Wrapped azimuth difference; the fold is replaced by a window on it.
    assign dphi         = pair.lead.phi - pair.second.phi;
    assign back_to_back = (dphi >= DPHI_LOW) && (dphi <= DPHI_HIGH);

    assign dijet = lead_pass && second_pass && back_to_back;

    always_comb
    begin
        result.dijet      = dijet;
        result.lead_idx   = dijet ? pair.lead_idx : '0;
        result.second_idx = dijet ? pair.second_idx : '0;
    end

endmodule

FILE: rtl/leading_dijet_back_to_back_select.sv
// Channel   Direction  tdata                               tuser       tlast
// s_axis    in         pt[15:0] eta[27:16] phi[39:28]      jet_valid   last of event
//                      tight_id[40]
// m_axis    out        lead_index[5:0] second_index[11:6]  is_dijet    (none)
// cfg       in         write enable, register index, data; no read-back
//
// One request is accepted every cycle when the output side keeps up.
// A closing request passes the input register, the running top-two update,
// then the cut and azimuth check into the output register, and leaves as a result.
// Each stage holds while the stage after it is full and stalled; bubbles close up.
// Reset clears the event state and loads the cut registers with their defaults.
module leading_dijet_back_to_back_select
    import ldbb_pkg::*;
#(
    parameter int MAX_JETS = MAX_JETS_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Configuration port.
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // Jet stream in.
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [S_TDATA_W-1:0]  s_axis_tdata,  // jet_pt, jet_eta, jet_phi, tight_id, zero pad
    input  logic [0:0]            s_axis_tuser,  // jet_valid
    input  logic                  s_axis_tlast,
    // Event results out.
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [M_TDATA_W-1:0]  m_axis_tdata,  // lead_index, second_index, zero pad
    output logic [0:0]            m_axis_tuser   // is_dijet
);

    logic [PT_W-1:0]      pt_cut_reg;
    logic [ETA_CUT_W-1:0] eta_cut_reg;

    logic      s1_v_reg;
    logic      s1_jet_valid_reg;
    logic      s1_last_reg;
    jet_core_t s1_jet_reg;

    logic      s2_v_reg;
    pair_t     s2_pair_reg;
    pair_t     pair;

    logic      out_v_reg;
    result_t   out_res_reg;
    result_t   result;

    logic      en1;
    logic      en2;
    logic      en3;
    logic      step;

    // Stage enables: a stage moves when it is empty or its successor moves.
    assign en3  = !out_v_reg || m_axis_tready;
    assign en2  = !s2_v_reg || en3;
    assign en1  = !s1_v_reg || en2;
    assign step = s1_v_reg && en2;

    assign s_axis_tready = en1;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pt_cut_reg  <= PT_CUT_RESET;
            eta_cut_reg <= ETA_CUT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_PT_CUT:  pt_cut_reg  <= cfg_data[PT_W-1:0];
                REG_ETA_CUT: eta_cut_reg <= cfg_data[ETA_CUT_W-1:0];
                default:     ;
            endcase
        end
    end

    // Valid flags of the three stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg  <= 1'b0;
            s2_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                s1_v_reg <= s_axis_tvalid;
            end
            if (en2)
            begin
                s2_v_reg <= s1_v_reg && s1_last_reg;
            end
            if (en3)
            begin
                out_v_reg <= s2_v_reg;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (en1 && s_axis_tvalid)
        begin
            s1_jet_valid_reg <= s_axis_tuser[0];
            s1_last_reg      <= s_axis_tlast;
            s1_jet_reg.pt    <= s_axis_tdata[15:0];
            s1_jet_reg.eta   <= s_axis_tdata[27:16];
            s1_jet_reg.phi   <= s_axis_tdata[39:28];
            s1_jet_reg.tight <= s_axis_tdata[40];
        end
        if (step && s1_last_reg)
        begin
            s2_pair_reg <= pair;
        end
        if (en3 && s2_v_reg)
        begin
            out_res_reg <= result;
        end
    end

    // Running top two of the current event.
    ldbb_rank #(
        .MAX_JETS (MAX_JETS)
    ) u_rank (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .jet_valid (s1_jet_valid_reg),
        .jet       (s1_jet_reg),
        .last      (s1_last_reg),
        .pair      (pair)
    );

    // Cuts and back-to-back check of the closed event.
    ldbb_judge u_judge (
        .pair    (s2_pair_reg),
        .pt_cut  (pt_cut_reg),
        .eta_cut (eta_cut_reg),
        .result  (result)
    );

    assign m_axis_tvalid = out_v_reg;
    assign m_axis_tuser  = out_res_reg.dijet;
    assign m_axis_tdata  = {{(M_TDATA_W - 2*IDX_W){1'b0}},
                            out_res_reg.second_idx, out_res_reg.lead_idx};

endmodule
